@@ rtl/core/wildcard_filter_to_regex_top_defines.svh @@
// Assertion macros shared by the wildcard filter converter.
`ifndef WILDCARD_FILTER_TO_REGEX_TOP_DEFINES_SVH
`define WILDCARD_FILTER_TO_REGEX_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define WFTR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("wftr assertion failed");
`define WFTR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wftr assertion failed");
`else
`define WFTR_ASSERT(lbl, clk, rst_n, prop)
`define WFTR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/wftr_pkg.sv @@
package wftr_pkg;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    localparam logic [3:0] CODE_EQ          = 4'd0;
    localparam logic [3:0] CODE_NE          = 4'd1;
    localparam logic [3:0] CODE_CONTAIN     = 4'd2;
    localparam logic [3:0] CODE_NOT_CONTAIN = 4'd3;
    localparam logic [3:0] CODE_BEGIN       = 4'd4;
    localparam logic [3:0] CODE_NOT_BEGIN   = 4'd5;
    localparam logic [3:0] CODE_END         = 4'd6;
    localparam logic [3:0] CODE_NOT_END     = 4'd7;

    typedef struct packed {
        logic       two;
        logic [7:0] ch0;
        logic [7:0] ch1;
        logic       cv0;
        logic       eov;
        logic [3:0] code;
        logic       rx;
    } t_op;

endpackage

@@ rtl/core/wftr_front.sv @@
`include "wildcard_filter_to_regex_top_defines.svh"

module wftr_front
    import wftr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_in,
    input  logic [3:0] i_compare_code,
    input  logic       i_first_char,
    input  logic       i_last_char,
    input  logic       i_empty_value,
    input  logic       i_full,
    output logic       o_push,
    output t_op        o_op
);

    logic       r_pend, r_lead, r_rx, r_pt;
    logic [3:0] r_held;
    logic       n_pend, n_lead, n_rx, n_pt;
    logic [3:0] n_held;

    logic       cur_pend, cur_lead, cur_rx, cur_pt;
    logic [3:0] cur_held;
    logic       is_star, is_quest, is_tilde, tail, fin, ne;
    logic [1:0] e_cnt;
    logic [7:0] ch0, ch1;
    logic       cv0, rx;
    logic [3:0] fcode;
    logic       accept;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        if (i_first_char || i_empty_value) begin
            cur_held = i_compare_code;
            cur_pt   = (i_compare_code > CODE_NE);
            cur_pend = 1'b0;
            cur_lead = 1'b0;
            cur_rx   = 1'b0;
        end else begin
            cur_held = r_held;
            cur_pt   = r_pt;
            cur_pend = r_pend;
            cur_lead = r_lead;
            cur_rx   = r_rx;
        end

        is_star  = (i_char_in == CH_STAR);
        is_quest = (i_char_in == CH_QUEST);
        is_tilde = (i_char_in == CH_TILDE);
        ne       = (cur_held == CODE_NE);

        n_held = cur_held;
        n_pt   = cur_pt;
        n_pend = cur_pend;
        n_lead = cur_lead;
        n_rx   = cur_rx;
        tail   = 1'b0;
        fin    = 1'b0;
        e_cnt  = 2'd0;
        ch0    = '0;
        ch1    = '0;
        cv0    = 1'b1;
        rx     = 1'b0;
        fcode  = cur_held;

        if (i_empty_value) begin
            fin = 1'b1;
        end else if (cur_pt) begin
            e_cnt = 2'd1;
            ch0   = i_char_in;
            fin   = i_last_char;
        end else if (i_first_char && is_star) begin
            if (i_last_char) begin
                e_cnt = 2'd2;
                ch0   = CH_DOT;
                ch1   = CH_STAR;
                fin   = 1'b1;
                rx    = 1'b1;
            end else begin
                n_lead = 1'b1;
            end
        end else begin
            if (is_star || is_quest) begin
                if (cur_pend) begin
                    n_pend = 1'b0;
                    e_cnt  = 2'd1;
                    ch0    = i_char_in;
                end else if (is_star && i_last_char) begin
                    tail = 1'b1;
                end else begin
                    n_rx = 1'b1;
                    ch0  = CH_DOT;
                    ch1  = CH_STAR;
                    e_cnt = is_star ? 2'd2 : 2'd1;
                end
            end else begin
                if (cur_pend) begin
                    n_pend = 1'b0;
                    ch0    = CH_TILDE;
                    ch1    = i_char_in;
                    if (is_tilde && !i_last_char) begin
                        n_pend = 1'b1;
                        e_cnt  = 2'd1;
                    end else begin
                        e_cnt = 2'd2;
                    end
                end else if (is_tilde && !i_last_char) begin
                    n_pend = 1'b1;
                end else begin
                    e_cnt = 2'd1;
                    ch0   = i_char_in;
                end
            end
            fin = i_last_char;
            rx  = n_rx;
            if (cur_lead && tail) begin
                fcode = ne ? CODE_NOT_CONTAIN : CODE_CONTAIN;
            end else if (cur_lead) begin
                fcode = ne ? CODE_NOT_END : CODE_END;
            end else if (tail) begin
                fcode = ne ? CODE_NOT_BEGIN : CODE_BEGIN;
            end
        end

        if (fin) begin
            n_pend = 1'b0;
            n_lead = 1'b0;
            n_rx   = 1'b0;
            if (e_cnt == 2'd0) begin
                e_cnt = 2'd1;
                ch0   = '0;
                cv0   = 1'b0;
            end
        end
    end

    assign o_push    = accept && (e_cnt != 2'd0);
    assign o_op.two  = (e_cnt == 2'd2);
    assign o_op.ch0  = ch0;
    assign o_op.ch1  = ch1;
    assign o_op.cv0  = cv0;
    assign o_op.eov  = fin;
    assign o_op.code = fin ? fcode : '0;
    assign o_op.rx   = fin ? rx : 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_lead <= 1'b0;
            r_rx   <= 1'b0;
            r_pt   <= 1'b0;
            r_held <= CODE_EQ;
        end else if (accept) begin
            r_pend <= n_pend;
            r_lead <= n_lead;
            r_rx   <= n_rx;
            r_pt   <= n_pt;
            r_held <= n_held;
        end
    end

    `WFTR_ASSERT(a_pend_not_pt, i_clk, i_rst_n, r_pend |-> !r_pt)
    `WFTR_ASSERT(a_lead_not_pt, i_clk, i_rst_n, r_lead |-> !r_pt)
    `WFTR_ASSERT_NEXT(a_empty_clears, i_clk, i_rst_n, accept && i_empty_value, !r_pend && !r_lead && !r_rx)

endmodule

@@ rtl/core/wftr_queue.sv @@
`include "wildcard_filter_to_regex_top_defines.svh"

module wftr_queue
    import wftr_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    input  logic i_pop,
    output t_op  o_head,
    output logic o_full,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_op              r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `WFTR_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push |-> !o_full)
    `WFTR_ASSERT(a_no_underflow, i_clk, i_rst_n, i_pop |-> !o_empty)

endmodule

@@ rtl/core/wftr_back.sv @@
`include "wildcard_filter_to_regex_top_defines.svh"

module wftr_back
    import wftr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_op        i_head,
    input  logic       i_head_valid,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_char_out,
    output logic       o_char_valid,
    output logic       o_end_of_value,
    output logic [3:0] o_result_code,
    output logic       o_is_regex
);

    logic       r_sel, r_valid;
    logic [7:0] r_char;
    logic       r_cv, r_eov, r_rx;
    logic [3:0] r_code;
    logic       load, first_of_two;

    assign load         = i_head_valid && (!r_valid || !i_stall);
    assign first_of_two = i_head.two && !r_sel;
    assign o_pop        = load && !first_of_two;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sel   <= first_of_two;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (first_of_two) begin
                r_char <= i_head.ch0;
                r_cv   <= 1'b1;
                r_eov  <= 1'b0;
                r_code <= '0;
                r_rx   <= 1'b0;
            end else begin
                r_char <= r_sel ? i_head.ch1 : i_head.ch0;
                r_cv   <= r_sel ? 1'b1 : i_head.cv0;
                r_eov  <= i_head.eov;
                r_code <= i_head.code;
                r_rx   <= i_head.rx;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_char_out     = r_char;
    assign o_char_valid   = r_cv;
    assign o_end_of_value = r_eov;
    assign o_result_code  = r_code;
    assign o_is_regex     = r_rx;

    `WFTR_ASSERT(a_sel_has_head, i_clk, i_rst_n, r_sel |-> i_head_valid)

endmodule

@@ rtl/core/wildcard_filter_to_regex_top.sv @@
// Wildcard filter value to pattern converter.
// Input channel (i_valid / o_stall): one character of a filter value per
// request with its compare code and first/last/empty marks. A request is
// taken at a rising edge with i_valid high and o_stall low.
// Output channel (o_valid / i_stall): one converted character per request;
// the last request of a value carries o_end_of_value, the final code and
// the pattern flag.
// The front classifies an item in the cycle of acceptance and writes a
// small queue; the back drains the queue through one output register.
// The back sends one result per cycle while i_stall is low; an item gives
// one result, or two when it expands to two characters ('*' to ".*", or a
// held '~' released with its successor); items that yield nothing take no
// slot at the back. The front takes one item per cycle while the queue has
// room. Reset clears the per-value state, empties the queue and clears the
// output valid flag. While i_stall is high the output register holds; the
// queue fills and then o_stall rises.
module wildcard_filter_to_regex_top
    import wftr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_in,
    input  logic [3:0] i_compare_code,
    input  logic       i_first_char,
    input  logic       i_last_char,
    input  logic       i_empty_value,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_char_out,
    output logic       o_char_valid,
    output logic       o_end_of_value,
    output logic [3:0] o_result_code,
    output logic       o_is_regex
);

    t_op  push_op, head;
    logic push, pop, full, empty;

    wftr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_char_in      (i_char_in),
        .i_compare_code (i_compare_code),
        .i_first_char   (i_first_char),
        .i_last_char    (i_last_char),
        .i_empty_value  (i_empty_value),
        .i_full         (full),
        .o_push         (push),
        .o_op           (push_op)
    );

    wftr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    wftr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_head_valid   (!empty),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_char_out     (o_char_out),
        .o_char_valid   (o_char_valid),
        .o_end_of_value (o_end_of_value),
        .o_result_code  (o_result_code),
        .o_is_regex     (o_is_regex)
    );

endmodule

@@ dv/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wftr_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic [3:0] code;
        logic       first;
        logic       last;
        logic       empty;
        logic       drain;
    } req_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       cv;
        logic       eov;
        logic [3:0] code;
        logic       rx;
    } res_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_char_in = 8'h00;
    logic [3:0] i_compare_code = 4'h0;
    logic       i_first_char = 1'b0;
    logic       i_last_char = 1'b0;
    logic       i_empty_value = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_char_out;
    logic       o_char_valid;
    logic       o_end_of_value;
    logic [3:0] o_result_code;
    logic       o_is_regex;

    wildcard_filter_to_regex_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_char_in     (i_char_in),
        .i_compare_code(i_compare_code),
        .i_first_char  (i_first_char),
        .i_last_char   (i_last_char),
        .i_empty_value (i_empty_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_char_out    (o_char_out),
        .o_char_valid  (o_char_valid),
        .o_end_of_value(o_end_of_value),
        .o_result_code (o_result_code),
        .o_is_regex    (o_is_regex)
    );

    always #1 i_clk = ~i_clk;

    req_t filter_q[$];
    res_t pattern_q[$];
    res_t step_res[$];

    // converter state
    logic [7:0] st_pend_ch;
    logic       st_pend_v;
    logic [7:0] st_prev_ch;
    logic       st_lead;
    logic       st_rx;
    logic [3:0] st_code;
    logic       st_pass;

    int  n_taken = 0;
    int  n_results = 0;
    int  n_values = 0;
    int  n_patterns = 0;
    int  n_errors = 0;
    int  n_full_stalls = 0;
    int  n_drains = 0;
    logic in_taken = 1'b0;

    wire quiet_run = (n_taken >= 120) && (n_taken < 170);

    task automatic clear_value();
        st_pend_ch = 8'h00;
        st_pend_v  = 1'b0;
        st_prev_ch = 8'h00;
        st_lead    = 1'b0;
        st_rx      = 1'b0;
    endtask

    task automatic emit_byte(input logic [7:0] ch);
        res_t r;
        r = '{ch: ch, cv: 1'b1, eov: 1'b0, code: CODE_EQ, rx: 1'b0};
        step_res.push_back(r);
    endtask

    task automatic close_value(input logic [3:0] code, input logic rx);
        res_t r;
        if (step_res.size() == 0) begin
            r = '{ch: 8'h00, cv: 1'b0, eov: 1'b0, code: CODE_EQ, rx: 1'b0};
        end else begin
            r = step_res.pop_back();
        end
        r.eov  = 1'b1;
        r.code = code;
        r.rx   = rx;
        step_res.push_back(r);
    endtask

    task automatic convert_char(input req_t q);
        logic       tail;
        logic       ne;
        logic [3:0] fcode;
        tail = 1'b0;
        step_res.delete();
        if (q.empty) begin
            clear_value();
            st_code = q.code;
            st_pass = (q.code > CODE_NE);
            close_value(q.code, 1'b0);
        end else begin
            if (q.first) begin
                clear_value();
                st_code = q.code;
                st_pass = (q.code > CODE_NE);
            end
            if (st_pass) begin
                emit_byte(q.ch);
                if (q.last) begin
                    close_value(st_code, 1'b0);
                    clear_value();
                end
            end else if (q.first && q.ch == CH_STAR) begin
                if (q.last) begin
                    emit_byte(CH_DOT);
                    emit_byte(CH_STAR);
                    close_value(st_code, 1'b1);
                    clear_value();
                end else begin
                    st_lead = 1'b1;
                end
            end else begin
                if (q.ch == CH_STAR || q.ch == CH_QUEST) begin
                    if (st_prev_ch == CH_TILDE && st_pend_v) begin
                        st_pend_v = 1'b0;
                        emit_byte(q.ch);
                    end else if (q.ch == CH_STAR && q.last) begin
                        tail = 1'b1;
                    end else begin
                        st_rx = 1'b1;
                        emit_byte(CH_DOT);
                        if (q.ch == CH_STAR) emit_byte(CH_STAR);
                    end
                end else begin
                    if (st_pend_v) begin
                        emit_byte(st_pend_ch);
                        st_pend_v = 1'b0;
                    end
                    if (q.ch == CH_TILDE && !q.last) begin
                        st_pend_ch = q.ch;
                        st_pend_v  = 1'b1;
                    end else begin
                        emit_byte(q.ch);
                    end
                end
                st_prev_ch = q.ch;
                if (q.last) begin
                    ne = (st_code == CODE_NE);
                    fcode = st_code;
                    if (st_lead && tail) fcode = ne ? CODE_NOT_CONTAIN : CODE_CONTAIN;
                    else if (st_lead) fcode = ne ? CODE_NOT_END : CODE_END;
                    else if (tail) fcode = ne ? CODE_NOT_BEGIN : CODE_BEGIN;
                    close_value(fcode, st_rx);
                    clear_value();
                end
            end
        end
        foreach (step_res[k]) pattern_q.push_back(step_res[k]);
    endtask

    task automatic add_char(input logic [7:0] ch, input logic [3:0] code, input logic first,
                            input logic last, input logic empty, input logic drain);
        req_t q;
        q = '{ch: ch, code: code, first: first, last: last, empty: empty, drain: drain};
        filter_q.push_back(q);
    endtask

    task automatic add_value(input string s, input logic [3:0] code, input logic drain);
        for (int k = 0; k < s.len(); k++) begin
            add_char(s[k], (k == 0) ? code : 4'($urandom_range(15)), k == 0,
                     k == s.len() - 1, 1'b0, drain && k == 0);
        end
    endtask

    task automatic add_random_value();
        int         len;
        int         pick;
        logic [3:0] code;
        logic [7:0] ch;
        logic       cut;
        len  = ($urandom_range(14) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 6);
        code = ($urandom_range(9) < 7) ? 4'($urandom_range(1)) : 4'($urandom_range(15));
        cut  = ($urandom_range(19) == 0);
        for (int k = 0; k < len; k++) begin
            pick = $urandom_range(9);
            case (pick)
                0, 1: ch = CH_STAR;
                2: ch = CH_QUEST;
                3, 4: ch = CH_TILDE;
                default: ch = 8'($urandom_range(255));
            endcase
            add_char(ch, (k == 0) ? code : 4'($urandom_range(15)), k == 0,
                     (k == len - 1) && !cut, 1'b0, 1'b0);
        end
    endtask

    // send requests
    req_t cur_req;
    logic idle_pick;
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || in_taken)) begin
            idle_pick = !quiet_run && ($urandom_range(99) < 12);
            if (filter_q.size() != 0 && !idle_pick
                && !(filter_q[0].drain && pattern_q.size() != 0)) begin
                cur_req = filter_q.pop_front();
                if (cur_req.drain) n_drains++;
                i_valid        <= 1'b1;
                i_char_in      <= cur_req.ch;
                i_compare_code <= cur_req.code;
                i_first_char   <= cur_req.first;
                i_last_char    <= cur_req.last;
                i_empty_value  <= cur_req.empty;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // hold off the receiver once, long enough to back up the input side
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!hold_done && n_taken >= 40) begin
            hold_done = 1'b1;
            hold_left = 80;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !quiet_run && ($urandom_range(99) < 12);
        end
    end

    always @(posedge i_clk) begin
        res_t got;
        res_t want;
        req_t q;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_valid && !o_stall;
            if (i_valid && o_stall) n_full_stalls++;
            if (o_valid && !i_stall) begin
                got = '{ch: o_char_out, cv: o_char_valid, eov: o_end_of_value,
                        code: o_result_code, rx: o_is_regex};
                n_results++;
                if (pattern_q.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result, expected none, actual ch=%h cv=%b eov=%b code=%0d rx=%b",
                             $time, got.ch, got.cv, got.eov, got.code, got.rx);
                end else begin
                    want = pattern_q.pop_front();
                    if (got.ch !== want.ch || got.cv !== want.cv || got.eov !== want.eov
                        || got.code !== want.code || got.rx !== want.rx) begin
                        n_errors++;
                        $display("%0t: mismatch, expected ch=%h cv=%b eov=%b code=%0d rx=%b, actual ch=%h cv=%b eov=%b code=%0d rx=%b",
                                 $time, want.ch, want.cv, want.eov, want.code, want.rx,
                                 got.ch, got.cv, got.eov, got.code, got.rx);
                    end
                    if (want.eov) n_values++;
                    if (want.eov && want.rx) n_patterns++;
                end
            end
            if (i_valid && !o_stall) begin
                q = '{ch: i_char_in, code: i_compare_code, first: i_first_char,
                      last: i_last_char, empty: i_empty_value, drain: 1'b0};
                convert_char(q);
                n_taken++;
            end
        end
    end

    initial begin
        ref_reset_state: begin
            clear_value();
            st_code = CODE_EQ;
            st_pass = 1'b0;
        end

        add_char(8'($urandom_range(255)), CODE_EQ, 1'b1, 1'b1, 1'b1, 1'b0);
        add_char(8'hFF, 4'hF, 1'b0, 1'b0, 1'b1, 1'b0);
        add_value("*", CODE_EQ, 1'b0);
        add_value("*a*", CODE_EQ, 1'b0);
        add_value("*a", CODE_NE, 1'b0);
        add_value("b*", CODE_NE, 1'b0);
        add_char(CH_QUEST, CODE_EQ, 1'b1, 1'b0, 1'b0, 1'b0);
        add_char(8'hFF, 4'hF, 1'b0, 1'b0, 1'b0, 1'b0);
        add_char(CH_STAR, 4'h0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_char(8'h00, 4'h0, 1'b0, 1'b1, 1'b0, 1'b0);
        add_value("~*~?~", CODE_EQ, 1'b0);
        add_value("*~", 4'd9, 1'b0);
        add_value("?", CODE_NOT_END, 1'b0);
        add_char(CH_TILDE, CODE_EQ, 1'b1, 1'b0, 1'b0, 1'b0);
        add_value("x", CODE_NE, 1'b1);
        add_char("y", 4'hA, 1'b0, 1'b1, 1'b0, 1'b0);

        while (filter_q.size() < 220) begin
            if (filter_q.size() >= 150 && filter_q.size() < 156) begin
                add_value("~a", CODE_EQ, 1'b1);
            end else if ($urandom_range(19) == 0) begin
                add_char(8'($urandom_range(255)), 4'($urandom_range(15)),
                         1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1, 1'b0);
            end else if ($urandom_range(9) == 0) begin
                add_char(8'($urandom_range(255)), 4'($urandom_range(15)),
                         1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, 1'b0);
            end else begin
                add_random_value();
            end
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (filter_q.size() != 0 || i_valid) @(negedge i_clk);
        while (pattern_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        if (pattern_q.size() != 0) begin
            n_errors++;
            $display("%0t: %0d expected results never arrived", $time, pattern_q.size());
        end
        $display("Ran %0d filter requests giving %0d results over %0d values (%0d patterns).",
                 n_taken, n_results, n_values, n_patterns);
        $display("Input backed up for %0d cycles; %0d drain pauses; %0d errors.",
                 n_full_stalls, n_drains, n_errors);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
